[hdl/memory_capability_table_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the capability table core
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MEMORY_CAPABILITY_TABLE_CORE_ASSERT_SVH
`define MEMORY_CAPABILITY_TABLE_CORE_ASSERT_SVH

// Next-cycle implication, masked while reset is asserted.
`define MCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("capability table port check failed");

// Same-cycle implication, masked while reset is asserted.
`define MCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("capability table port check failed");

// Next-cycle implication that also holds through reset.
`define MCT_ASSERT_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("capability table reset check failed");

`endif

[hdl/mct_pkg.sv]
// ----------------------------------------------------------------------------
// mct_pkg
// Types and constants shared by the capability table core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mct_pkg;

  // operation codes
  localparam logic [1:0] OP_DERIVE = 2'd0;
  localparam logic [1:0] OP_REVOKE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // slot arithmetic: index + fuel, compared against depths up to 511
  localparam int SLOT_W = 9;

  typedef struct packed {
    logic [6:0]  owner;
    logic [6:0]  fuel;
    logic [6:0]  fuel_limit;
    logic [2:0]  perms;
    logic [31:0] base;
    logic [31:0] size;
  } entry_t;

  localparam entry_t ROOT_ENTRY = '{
    owner:      7'd0,
    fuel:       7'd64,
    fuel_limit: 7'd64,
    perms:      3'h7,
    base:       32'h8000_0000,
    size:       32'h0001_0000
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECIDE,
    ST_CHILD
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic commit;
    logic child_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic derive_ok;
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/mct_req_if.sv]
// ----------------------------------------------------------------------------
// mct_req_if
// Request channel: operation and derive arguments with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [6:0]  owner;
  logic [5:0]  index;
  logic [6:0]  child_fuel;
  logic [31:0] region_base;
  logic [31:0] region_size;
  logic [2:0]  perms;

  modport source (
    output valid, operation, owner, index, child_fuel, region_base, region_size, perms,
    input  ready
  );

  modport sink (
    input  valid, operation, owner, index, child_fuel, region_base, region_size, perms,
    output ready
  );
endinterface

`default_nettype wire

[hdl/mct_rsp_if.sv]
// ----------------------------------------------------------------------------
// mct_rsp_if
// Response channel: status and derived child index with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mct_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [5:0] new_index;

  modport source (
    output valid, ok, new_index,
    input  ready
  );

  modport sink (
    input  valid, ok, new_index,
    output ready
  );
endinterface

`default_nettype wire

[hdl/mct_ram.sv]
// ----------------------------------------------------------------------------
// mct_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mct_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/mct_controller.sv]
// ----------------------------------------------------------------------------
// mct_controller
// Sequencer for one transaction: fetch, decide, optional child write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mct_controller (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire mct_pkg::dp_status_t status,
  output mct_pkg::ctrl_cmd_t      cmd
);

  mct_pkg::state_t state_r;
  mct_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mct_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mct_pkg::ST_FETCH;
      end
      mct_pkg::ST_FETCH: begin
        state_nxt = mct_pkg::ST_DECIDE;
      end
      mct_pkg::ST_DECIDE: begin
        if (out_free) begin
          state_nxt = status.derive_ok ? mct_pkg::ST_CHILD : mct_pkg::ST_IDLE;
        end
      end
      mct_pkg::ST_CHILD: begin
        state_nxt = mct_pkg::ST_IDLE;
      end
      default: state_nxt = mct_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      mct_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      mct_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      mct_pkg::ST_DECIDE: begin
        cmd.commit = out_free;
      end
      mct_pkg::ST_CHILD: begin
        cmd.child_wr = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mct_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hdl/mct_datapath.sv]
// ----------------------------------------------------------------------------
// mct_datapath
// Entry store, live bits, check pipeline and response payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mct_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mct_pkg::ctrl_cmd_t  cmd,
  output mct_pkg::dp_status_t      status,
  input  wire logic [1:0]          in_operation,
  input  wire logic [6:0]          in_owner,
  input  wire logic [5:0]          in_index,
  input  wire logic [6:0]          in_child_fuel,
  input  wire logic [31:0]         in_region_base,
  input  wire logic [31:0]         in_region_size,
  input  wire logic [2:0]          in_perms,
  output logic                     out_ok,
  output logic [5:0]               out_new_index
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = mct_pkg::SLOT_W;
  localparam int EW = $bits(mct_pkg::entry_t);
  localparam logic [SW-1:0] DEPTH_S = SW'(TABLE_DEPTH);

  // request capture
  logic [1:0]  req_op_r;
  logic [6:0]  req_owner_r;
  logic [5:0]  req_index_r;
  logic [6:0]  req_fuel_r;
  logic [31:0] req_base_r;
  logic [31:0] req_size_r;
  logic [2:0]  req_perms_r;

  // table state
  logic [TABLE_DEPTH-1:0] live_r;
  logic [TABLE_DEPTH-1:0] live_nxt;
  logic                   root_written_r;
  logic                   root_written_nxt;

  // check stage
  mct_pkg::entry_t ent_r;
  logic            owner_ok_r;
  logic            fuel_ok_r;
  logic            perms_ok_r;
  logic [32:0]     hi_r;
  logic [32:0]     end_r;
  logic [SW-1:0]   child_r;
  logic [SW-1:0]   rv_lo_r;
  logic [SW-1:0]   rv_hi_r;

  // response payload
  logic       ok_r;
  logic [5:0] new_index_r;

  // RAM
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;
  logic [AW-1:0]   addr;

  mct_pkg::entry_t ent_rd;
  mct_pkg::entry_t parent_wr;
  mct_pkg::entry_t child_wr;
  logic            idx_ok;
  logic            derive_ok;
  logic            revoke_ok;
  logic            delete_ok;
  logic [TABLE_DEPTH-1:0] rv_mask;

  mct_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (AW'(in_index)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op_r    <= in_operation;
      req_owner_r <= in_owner;
      req_index_r <= in_index;
      req_fuel_r  <= in_child_fuel;
      req_base_r  <= in_region_base;
      req_size_r  <= in_region_size;
      req_perms_r <= in_perms;
    end
  end

  assign addr   = AW'(req_index_r);
  assign idx_ok = SW'(req_index_r) < DEPTH_S;

  // entry 0 shows the root capability until first written
  always_comb begin
    if (req_index_r == 6'd0 && !root_written_r) begin
      ent_rd = mct_pkg::ROOT_ENTRY;
    end else begin
      ent_rd = mct_pkg::entry_t'(ram_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      ent_r      <= ent_rd;
      owner_ok_r <= idx_ok && live_r[addr] && (ent_rd.owner == req_owner_r);
      fuel_ok_r  <= (req_fuel_r != 7'd0) && (req_fuel_r < ent_rd.fuel);
      perms_ok_r <= (ent_rd.perms & req_perms_r) == req_perms_r;
      hi_r       <= {1'b0, ent_rd.base} + {1'b0, ent_rd.size};
      end_r      <= {1'b0, req_base_r} + {1'b0, req_size_r};
      child_r    <= SW'(req_index_r) + SW'(ent_rd.fuel) - SW'(req_fuel_r);
      rv_lo_r    <= SW'(req_index_r) + SW'(ent_rd.fuel);
      rv_hi_r    <= SW'(req_index_r) + SW'(ent_rd.fuel_limit);
    end
  end

  assign derive_ok = (req_op_r == mct_pkg::OP_DERIVE) && owner_ok_r && fuel_ok_r &&
                     perms_ok_r && (req_base_r >= ent_r.base) && (end_r <= hi_r) &&
                     (child_r < DEPTH_S);
  assign revoke_ok = (req_op_r == mct_pkg::OP_REVOKE) && owner_ok_r;
  assign delete_ok = (req_op_r == mct_pkg::OP_DELETE) && owner_ok_r;

  assign status.derive_ok = derive_ok;

  // child slots of a revoked entry, cleared in one go
  always_comb begin
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      rv_mask[s] = (SW'(s) >= rv_lo_r) && (SW'(s) < rv_hi_r);
    end
  end

  always_comb begin
    parent_wr = ent_r;
    if (derive_ok) begin
      parent_wr.fuel = ent_r.fuel - req_fuel_r;
    end else begin
      parent_wr.fuel = ent_r.fuel_limit;
    end
    child_wr = '{
      owner:      ent_r.owner,
      fuel:       req_fuel_r,
      fuel_limit: req_fuel_r,
      perms:      req_perms_r,
      base:       req_base_r,
      size:       req_size_r
    };
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = EW'(parent_wr);
    if (cmd.child_wr) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(child_r);
      ram_wdata = EW'(child_wr);
    end else if (cmd.commit && (derive_ok || revoke_ok)) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    live_nxt         = live_r;
    root_written_nxt = root_written_r;
    if (cmd.child_wr) begin
      live_nxt[AW'(child_r)] = 1'b1;
    end else if (cmd.commit) begin
      if (revoke_ok) begin
        live_nxt = live_r & ~rv_mask;
      end
      if (delete_ok) begin
        live_nxt[addr] = 1'b0;
      end
      if ((derive_ok || revoke_ok) && addr == '0) begin
        root_written_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r         <= TABLE_DEPTH'(1);
      root_written_r <= 1'b0;
    end else begin
      live_r         <= live_nxt;
      root_written_r <= root_written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_r        <= derive_ok || revoke_ok || delete_ok;
      new_index_r <= derive_ok ? child_r[5:0] : 6'd0;
    end
  end

  assign out_ok        = ok_r;
  assign out_new_index = new_index_r;

endmodule

`default_nettype wire

[hdl/memory_capability_table_core.sv]
// ----------------------------------------------------------------------------
// memory_capability_table_core
// A result passes the RAM read register, the check stage and the response register.
// One transaction is in flight at a time; a successful derive adds a child step,
//   the child write on the single RAM write port.
// A stalled response holds the next transaction in its decide step.
// Reset: synchronous, active low; the table is back to the root capability
//   at once (live bits in flip-flops, no clearing pass).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Structure
//   mct_controller : four-state sequencer (idle, fetch, decide, child) and
//                    the response valid flag.
//   mct_datapath   : request capture, the entry RAM, one live bit per slot,
//                    the two-stage check pipeline and the response payload.
//
// Sequence of a transaction
//   accept  - request fields captured, entry read from RAM at the index.
//   fetch   - owner match, fuel range and permission subset evaluated; the
//             33-bit region ends, the child slot and the revoke range summed.
//   decide  - bound compares and child slot range finish the checks. The
//             parent entry is written back (fuel drop on derive, fuel
//             restore on revoke), live bits are cleared for delete/revoke,
//             and the response is loaded. Waits here while the response
//             register is still occupied.
//   child   - successful derive only: child entry written, its live bit set.
//
// Notes
//   An invalid entry is a cleared live bit; its RAM contents are ignored.
//   Entry 0 reads as the root capability until it is first written back.
//   A revoke clears its whole child range at once through a
//   per-slot range compare on the live vector.

module memory_capability_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mct_req_if.sink   in_chan,
  mct_rsp_if.source out_chan
);

  mct_pkg::ctrl_cmd_t  cmd;
  mct_pkg::dp_status_t status;

  mct_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mct_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_operation   (in_chan.operation),
    .in_owner       (in_chan.owner),
    .in_index       (in_chan.index),
    .in_child_fuel  (in_chan.child_fuel),
    .in_region_base (in_chan.region_base),
    .in_region_size (in_chan.region_size),
    .in_perms       (in_chan.perms),
    .out_ok         (out_chan.ok),
    .out_new_index  (out_chan.new_index)
  );

endmodule

`default_nettype wire

[hdl/mct_checker.sv]
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks on the capability table core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "memory_capability_table_core_assert.svh"

module mct_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_ok,
  input wire logic [5:0] out_new_index
);

  // one transaction in flight: no new request taken right after one
  `MCT_ASSERT_NEXT(a_single_flight, in_valid && in_ready, !in_ready)

  // a failed operation never reports a child
  `MCT_ASSERT_NOW(a_fail_no_index, out_valid && !out_ok, out_new_index == 6'd0)

  // a stalled response holds
  `MCT_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready,
                   out_valid && $stable(out_ok) && $stable(out_new_index))

  // reset empties the response register
  `MCT_ASSERT_NEXT_RST(a_rst_rsp, !rst_n, !out_valid)

endmodule

bind memory_capability_table_core mct_checker u_mct_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_ok        (out_chan.ok),
  .out_new_index (out_chan.new_index)
);

`default_nettype wire
